// File: sv/mcs_pkg.sv
// package for the multiplexed counter scaler: status codes, widths, command types
// no dependencies
`default_nettype none
package mcs_pkg;
    localparam int CountW = 64;
    localparam int ScaledW = 63;
    localparam int NumSlots = 8;
    localparam int SlotW = 3;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_RUN_ZERO = 2'd1;
    localparam logic [1:0] STATUS_DECREASE = 2'd2;
    localparam logic [1:0] STATUS_GLITCH = 2'd3;

    localparam logic CFG_GROUP_MODE = 1'b0;
    localparam logic CFG_WATCH = 1'b1;

    localparam logic [63:0] GLITCH_FLOOR = 64'h0000_4000_0000_0000;
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic load;        // capture request and run the front checks
        logic mul;         // accumulate one 32x32 partial product
        logic [1:0] part;  // which partial: 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 hi*hi
        logic div_start;   // load divider
        logic div_step;    // one quotient bit
        logic store;       // write quotient of current slot
        logic commit;      // update history
        logic [SlotW-1:0] slot;
    } mcs_cmd_t;

    typedef struct packed {
        logic [1:0] front_status; // checks before scaling
        logic [3:0] used;         // number of slots to scale
        logic glitch;             // glitch on current slot
    } mcs_stat_t;
endpackage
`default_nettype wire

// File: sv/mcs_datapath.sv
// datapath: request capture, checks, serial multiply-divide, history registers
// depends on mcs_pkg
`default_nettype none
module mcs_datapath #(
    parameter int MAX_COUNTERS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic group_mode,
    input  wire logic watch_other_process,
    input  wire logic [63:0] enabled_time,
    input  wire logic [63:0] running_time,
    input  wire logic [3:0] entry_count,
    input  wire logic [63:0] counts [mcs_pkg::NumSlots],
    input  wire mcs_pkg::mcs_cmd_t cmd,
    output mcs_pkg::mcs_stat_t stat,
    output logic [62:0] quot [mcs_pkg::NumSlots]
);
    logic [63:0] en_reg, run_reg;
    logic [63:0] cnt_reg [mcs_pkg::NumSlots];
    logic [3:0] ent_reg;
    logic gm_reg;
    logic [63:0] prev_lead_reg, prev_running_reg;
    logic [63:0] prev_counts_reg [mcs_pkg::NumSlots];
    logic [127:0] prod_reg;
    logic [63:0] rem_reg, qacc_reg;
    logic [63:0] lo_reg;
    logic sat_reg;
    logic [62:0] quot_reg [mcs_pkg::NumSlots];

    logic [63:0] lead, cur, prevc, dv, dt;
    logic [3:0] used;
    logic [64:0] shifted;
    logic take;

    // one 32x32 partial product per cycle, four partials per 64x64 product
    logic [31:0] mul_a, mul_b;
    logic [63:0] partial;
    logic [127:0] partial_sh;
    assign cur = cnt_reg[cmd.slot];

    always_comb
    begin
        mul_a = cmd.part[1] ? cur[63:32] : cur[31:0];
        mul_b = cmd.part[0] ? en_reg[63:32] : en_reg[31:0];
        partial = {32'd0, mul_a} * {32'd0, mul_b};
        case (cmd.part)
            2'd0: partial_sh = {64'd0, partial};
            2'd3: partial_sh = {partial, 64'd0};
            default: partial_sh = {32'd0, partial, 32'd0};
        endcase
    end

    always_comb
    begin
        lead = gm_reg ? {60'd0, ent_reg} : cnt_reg[0];
        if (ent_reg > 4'(MAX_COUNTERS))
            used = 4'(MAX_COUNTERS);
        else
            used = ent_reg;
        if (!gm_reg)
            used = 4'd1;
        stat.used = used;
        if (run_reg == 64'd0)
            stat.front_status = mcs_pkg::STATUS_RUN_ZERO;
        else if (prev_lead_reg != 64'd0 && prev_lead_reg > lead)
            stat.front_status = mcs_pkg::STATUS_DECREASE;
        else
            stat.front_status = mcs_pkg::STATUS_OK;
        prevc = gm_reg ? prev_counts_reg[cmd.slot] : prev_lead_reg;
        dv = cur - prevc;
        dt = run_reg - prev_running_reg;
        stat.glitch = watch_other_process && (cur >= mcs_pkg::GLITCH_FLOOR)
            && (dv >= 64'(dt * 64'd6));
        shifted = {rem_reg, lo_reg[63]};
        take = shifted[64] || (shifted[63:0] >= run_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            en_reg <= enabled_time;
            run_reg <= running_time;
            ent_reg <= entry_count;
            gm_reg <= group_mode;
            for (int i = 0; i < mcs_pkg::NumSlots; i++)
            begin
                cnt_reg[i] <= counts[i];
                quot_reg[i] <= '0;
            end
        end
        if (cmd.mul)
            prod_reg <= (cmd.part == 2'd0) ? partial_sh : (prod_reg + partial_sh);
        if (cmd.div_start)
        begin
            rem_reg <= prod_reg[127:64];
            lo_reg <= prod_reg[63:0];
            qacc_reg <= '0;
            sat_reg <= prod_reg[127:64] >= run_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg <= take ? (shifted[63:0] - run_reg) : shifted[63:0];
            lo_reg <= {lo_reg[62:0], 1'b0};
            qacc_reg <= {qacc_reg[62:0], take};
        end
        if (cmd.store)
            quot_reg[cmd.slot] <= (sat_reg || qacc_reg[63]) ? mcs_pkg::SAT_MAX[62:0]
                : qacc_reg[62:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lead_reg <= '0;
            prev_running_reg <= '0;
            for (int i = 0; i < mcs_pkg::NumSlots; i++)
                prev_counts_reg[i] <= '0;
        end
        else if (cmd.commit)
        begin
            prev_lead_reg <= lead;
            prev_running_reg <= run_reg;
            if (gm_reg)
                for (int i = 0; i < mcs_pkg::NumSlots; i++)
                    if (4'(i) < used)
                        prev_counts_reg[i] <= cnt_reg[i];
        end
    end

    assign quot = quot_reg;
endmodule
`default_nettype wire

// File: sv/mcs_ctrl.sv
// controller: sequences checks, glitch scan and per-slot divide, holds result
// depends on mcs_pkg
`default_nettype none
module mcs_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  wire logic out_stall,
    input  wire mcs_pkg::mcs_stat_t stat,
    output mcs_pkg::mcs_cmd_t cmd,
    output logic [1:0] status,
    output logic zero_out
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL = 3'd3;
    localparam logic [2:0] S_DIVL = 3'd4;
    localparam logic [2:0] S_DIV = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [3:0] slot_reg, slot_next;
    logic [6:0] step_reg, step_next;
    logic [1:0] status_reg, status_next;
    logic zero_reg, zero_next;

    always_comb
    begin
        state_next = state_reg;
        slot_next = slot_reg;
        step_next = step_reg;
        status_next = status_reg;
        zero_next = zero_reg;
        cmd = '0;
        cmd.slot = slot_reg[2:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                slot_next = '0;
                if (stat.front_status != mcs_pkg::STATUS_OK)
                begin
                    status_next = stat.front_status;
                    zero_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // glitch check over every used slot before any history update
                if (slot_reg >= stat.used)
                begin
                    slot_next = '0;
                    step_next = '0;
                    state_next = (stat.used == 4'd0) ? S_OUT : S_MUL;
                    status_next = mcs_pkg::STATUS_OK;
                    zero_next = 1'b0;
                    if (stat.used == 4'd0)
                        cmd.commit = 1'b1;
                end
                else if (stat.glitch)
                begin
                    status_next = mcs_pkg::STATUS_GLITCH;
                    zero_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                    slot_next = slot_reg + 4'd1;
            end
            S_MUL:
            begin
                // four partial products, one per cycle
                cmd.mul = 1'b1;
                cmd.part = step_reg[1:0];
                if (step_reg == 7'd3)
                    state_next = S_DIVL;
                else
                    step_next = step_reg + 7'd1;
            end
            S_DIVL:
            begin
                cmd.div_start = 1'b1;
                step_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == 7'd64)
                begin
                    cmd.store = 1'b1;
                    slot_next = slot_reg + 4'd1;
                    step_next = '0;
                    if (slot_reg + 4'd1 >= stat.used)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_MUL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    step_next = step_reg + 7'd1;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg <= '0;
            step_reg <= '0;
            status_reg <= mcs_pkg::STATUS_OK;
            zero_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            step_reg <= step_next;
            status_reg <= status_next;
            zero_reg <= zero_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status = status_reg;
    assign zero_out = zero_reg;
endmodule
`default_nettype wire

// File: sv/multiplexed_counter_scaler_core.sv
// top level of the multiplexed counter scaler: config registers, controller, datapath
// depends on mcs_pkg, mcs_ctrl, mcs_datapath
`default_nettype none
// Scales up to eight raw event counts to the full enabled time as
// floor(count * enabled_time / running_time), saturating at 2^63-1. One request
// is handled at a time: a request is taken while the block is idle, checked
// (zero running time, decreasing lead value), then every used count is scanned
// for a glitch one per cycle, then each used count is multiplied from four
// 32x32 partials, loaded into a shared restoring divider and divided at one
// quotient bit per cycle, then its quotient is stored. The result then waits in
// the output register until taken, and the block returns to idle before the
// next request can be taken. On an error the remaining steps are skipped, all
// scaled outputs are zero and the remembered snapshot is left as it was.
module multiplexed_counter_scaler_core #(
    parameter int MAX_COUNTERS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // config write channel
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic cfg_index,
    input  wire logic [63:0] cfg_data,
    // request channel
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic [63:0] enabled_time,
    input  wire logic [63:0] running_time,
    input  wire logic [3:0] entry_count,
    input  wire logic [63:0] count_0,
    input  wire logic [63:0] count_1,
    input  wire logic [63:0] count_2,
    input  wire logic [63:0] count_3,
    input  wire logic [63:0] count_4,
    input  wire logic [63:0] count_5,
    input  wire logic [63:0] count_6,
    input  wire logic [63:0] count_7,
    // result channel
    output logic out_valid,
    input  wire logic out_stall,
    output logic [1:0] status,
    output logic [62:0] scaled_0,
    output logic [62:0] scaled_1,
    output logic [62:0] scaled_2,
    output logic [62:0] scaled_3,
    output logic [62:0] scaled_4,
    output logic [62:0] scaled_5,
    output logic [62:0] scaled_6,
    output logic [62:0] scaled_7
);
    logic group_mode_reg, watch_reg;
    logic [63:0] counts [mcs_pkg::NumSlots];
    logic [62:0] quot [mcs_pkg::NumSlots];
    mcs_pkg::mcs_cmd_t cmd;
    mcs_pkg::mcs_stat_t stat;
    logic zero_out;

    // config always taken; only two registers so a one-bit index covers the list
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_mode_reg <= 1'b0;
            watch_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mcs_pkg::CFG_GROUP_MODE: group_mode_reg <= cfg_data[0];
                mcs_pkg::CFG_WATCH: watch_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign counts[0] = count_0;
    assign counts[1] = count_1;
    assign counts[2] = count_2;
    assign counts[3] = count_3;
    assign counts[4] = count_4;
    assign counts[5] = count_5;
    assign counts[6] = count_6;
    assign counts[7] = count_7;

    mcs_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stat(stat),
        .cmd(cmd),
        .status(status),
        .zero_out(zero_out)
    );

    mcs_datapath #(.MAX_COUNTERS(MAX_COUNTERS)) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .group_mode(group_mode_reg),
        .watch_other_process(watch_reg),
        .enabled_time(enabled_time),
        .running_time(running_time),
        .entry_count(entry_count),
        .counts(counts),
        .cmd(cmd),
        .stat(stat),
        .quot(quot)
    );

    // errors force every scaled value to zero; unused slots were cleared on load
    assign scaled_0 = zero_out ? '0 : quot[0];
    assign scaled_1 = zero_out ? '0 : quot[1];
    assign scaled_2 = zero_out ? '0 : quot[2];
    assign scaled_3 = zero_out ? '0 : quot[3];
    assign scaled_4 = zero_out ? '0 : quot[4];
    assign scaled_5 = zero_out ? '0 : quot[5];
    assign scaled_6 = zero_out ? '0 : quot[6];
    assign scaled_7 = zero_out ? '0 : quot[7];
endmodule
`default_nettype wire
